[hw/rtl/clt_pkg.sv]
package clt_pkg;

  localparam int MAX_TOKENS = 1024;
  localparam int MAX_LINE   = 8192;

  localparam int POS_W = $clog2(MAX_LINE);
  localparam int TOK_W = $clog2(MAX_TOKENS + 1);

  localparam int RES_MAX = 4;
  localparam int CNT_W   = $clog2(RES_MAX + 1);
  localparam int PTR_W   = $clog2(RES_MAX);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE - 1);
  localparam logic [TOK_W-1:0] TOK_LIMIT = TOK_W'(MAX_TOKENS);

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // register index (byte address bit 2)
  localparam logic REG_IGNORE_QUOTES = 1'b0;

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_TOKEN,
    MODE_QUOTE,
    MODE_COMMENT
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  token_byte;
    logic [9:0]  token_index;
    logic [10:0] token_total;
    logic        run_last;
  } out_t;

  typedef struct packed {
    mode_t            mode;
    logic             slash_held;
    logic             star_seen;
    logic [7:0]       prev_byte_1;
    logic [7:0]       prev_byte_2;
    logic [POS_W-1:0] byte_position;
    logic [TOK_W-1:0] token_counter;
    logic             line_finished;
  } st_t;

  localparam st_t ST_RESET = '{
    mode:          MODE_BETWEEN,
    slash_held:    1'b0,
    star_seen:     1'b0,
    prev_byte_1:   8'h00,
    prev_byte_2:   8'h00,
    byte_position: '0,
    token_counter: '0,
    line_finished: 1'b0
  };

endpackage

[hw/rtl/clt_step.sv]
module clt_step (
  input  clt_pkg::st_t                         st,
  input  clt_pkg::in_t                         item,
  input  logic                                 ignore_quotes,
  output clt_pkg::st_t                         st_next,
  output clt_pkg::out_t [clt_pkg::RES_MAX-1:0] res,
  output logic [clt_pkg::CNT_W-1:0]            res_cnt
);
  import clt_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  typedef struct packed {
    st_t                      st;
    logic [CNT_W-1:0]         cnt;
    out_t [RES_MAX-1:0]       res;
  } acc_t;

  function automatic logic is_space(logic [7:0] c);
    return (c <= CH_SPACE) || c[7];
  endfunction

  function automatic st_t shift_in(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    r.prev_byte_2 = s.prev_byte_1;
    r.prev_byte_1 = c;
    return r;
  endfunction

  function automatic acc_t emit(acc_t a, logic [1:0] kind, logic [7:0] b, logic [9:0] idx);
    acc_t r;
    r = a;
    if (a.cnt < CNT_W'(RES_MAX)) begin
      r.res[a.cnt[PTR_W-1:0]].result_kind = kind;
      r.res[a.cnt[PTR_W-1:0]].token_byte  = b;
      r.res[a.cnt[PTR_W-1:0]].token_index = idx;
      r.res[a.cnt[PTR_W-1:0]].token_total = 11'(a.st.token_counter);
      r.res[a.cnt[PTR_W-1:0]].run_last    = 1'b0;
      r.cnt = a.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [9:0] cur_idx(acc_t a);
    return 10'(a.st.token_counter - 1'b1);
  endfunction

  function automatic acc_t end_token(acc_t a);
    return emit(a, KIND_END, 8'h00, cur_idx(a));
  endfunction

  function automatic acc_t finish(acc_t a);
    acc_t r;
    r = a;
    r.st.line_finished = 1'b1;
    r.st.slash_held    = 1'b0;
    r.st.star_seen     = 1'b0;
    return r;
  endfunction

  function automatic acc_t do_process(acc_t a, logic [7:0] c, logic iq);
    acc_t r;
    logic qa;
    logic lim;
    r   = a;
    qa  = (c == CH_QUOTE) && !iq;
    lim = a.st.token_counter >= TOK_LIMIT;
    case (a.st.mode)
      MODE_BETWEEN: begin
        if (c == CH_NUL) begin
          r = finish(r);
        end else if (is_space(c)) begin
          r.st = shift_in(r.st, c);
        end else if (c == CH_SLASH) begin
          r.st.slash_held = 1'b1;
        end else begin
          r.st.token_counter = r.st.token_counter + 1'b1;
          if (qa) begin
            r.st.mode = MODE_QUOTE;
          end else begin
            r = emit(r, KIND_BYTE, c, cur_idx(r));
            r.st.mode = MODE_TOKEN;
          end
          r.st = shift_in(r.st, c);
        end
      end
      MODE_TOKEN: begin
        if (c == CH_NUL) begin
          r = finish(end_token(r));
        end else if (is_space(c) || qa) begin
          r = end_token(r);
          if (lim) begin
            r = finish(r);
          end else begin
            if (qa) begin
              r.st.token_counter = r.st.token_counter + 1'b1;
              r.st.mode = MODE_QUOTE;
            end else begin
              r.st.mode = MODE_BETWEEN;
            end
            r.st = shift_in(r.st, c);
          end
        end else if (c == CH_SLASH) begin
          r.st.slash_held = 1'b1;
        end else begin
          r = emit(r, KIND_BYTE, c, cur_idx(r));
          r.st = shift_in(r.st, c);
        end
      end
      MODE_QUOTE: begin
        if (c == CH_NUL) begin
          r = finish(end_token(r));
        end else if (c == CH_QUOTE) begin
          r = end_token(r);
          if (lim) begin
            r = finish(r);
          end else begin
            r.st.mode = MODE_BETWEEN;
            r.st = shift_in(r.st, c);
          end
        end else begin
          r = emit(r, KIND_BYTE, c, cur_idx(r));
          r.st = shift_in(r.st, c);
        end
      end
      default: begin
        if (c == CH_NUL) begin
          r = finish(r);
        end else begin
          if (a.st.star_seen && c == CH_SLASH) begin
            r.st.mode      = MODE_BETWEEN;
            r.st.star_seen = 1'b0;
          end else begin
            r.st.star_seen = (c == CH_STAR);
          end
          r.st = shift_in(r.st, c);
        end
      end
    endcase
    return r;
  endfunction

  // held slash: the byte after it decides
  function automatic acc_t resolve(acc_t a, logic [7:0] c, logic iq);
    acc_t r;
    logic keep;
    logic in_tok;
    r      = a;
    in_tok = (a.st.mode == MODE_TOKEN);
    // "scheme://" style: lower-case letter, colon, slash at position 3 or later
    keep   = (a.st.byte_position >= POS_W'(4)) && (a.st.prev_byte_1 == CH_COLON) &&
             (a.st.prev_byte_2 inside {[CH_LOW_A:CH_LOW_Z]});
    r.st.slash_held = 1'b0;
    if (c == CH_SLASH && !keep) begin
      if (in_tok) r = end_token(r);
      r = finish(r);
    end else if (c == CH_STAR) begin
      if (in_tok) r = end_token(r);
      if (in_tok && a.st.token_counter >= TOK_LIMIT) begin
        r = finish(r);
      end else begin
        r.st.mode      = MODE_COMMENT;
        r.st.star_seen = 1'b1;
        r.st = shift_in(shift_in(r.st, CH_SLASH), CH_STAR);
      end
    end else begin
      if (!in_tok) begin
        r.st.token_counter = r.st.token_counter + 1'b1;
        r.st.mode = MODE_TOKEN;
      end
      r = emit(r, KIND_BYTE, CH_SLASH, cur_idx(r));
      r.st = shift_in(r.st, CH_SLASH);
      r = do_process(r, c, iq);
    end
    return r;
  endfunction

  always_comb begin
    acc_t a;
    logic [7:0] c;
    a.st  = st;
    a.cnt = '0;
    a.res = '0;
    c     = item.in_byte;
    if (!st.line_finished) begin
      if (st.byte_position >= POS_LIMIT) c = CH_NUL;
      a = st.slash_held ? resolve(a, c, ignore_quotes) : do_process(a, c, ignore_quotes);
      if (a.st.byte_position != POS_LIMIT) a.st.byte_position = a.st.byte_position + 1'b1;
    end
    if (item.line_last) begin
      if (!a.st.line_finished) begin
        a = a.st.slash_held ? resolve(a, CH_NUL, ignore_quotes)
                            : do_process(a, CH_NUL, ignore_quotes);
      end
      a = emit(a, KIND_SUMMARY, 8'h00, 10'd0);
      a.st = ST_RESET;
    end
    if (a.cnt != '0) a.res[PTR_W'(a.cnt - 1'b1)].run_last = 1'b1;
    st_next = a.st;
    res     = a.res;
    res_cnt = a.cnt;
  end

endmodule

[hw/rtl/command_line_tokenizer_top.sv]
// channel   dir  handshake              payload
// char      in   char_valid/char_stall  char_data  (in_byte, line_last)
// tok       out  tok_valid/tok_stall    tok_data   (kind, byte, index, total, run_last)
// apb       in   psel/penable/pwrite    paddr[2:0], pwdata/prdata 32b, pready tied high
//
// One byte per cycle while tok_stall is low and each byte gives at most one result; a byte
// giving several results holds the input side until the single result port has passed them all.
// A byte passes the input register and then the result holder before its first result beat.
// rst is synchronous, active high; clears line state and ignore_quotes.
// tok_stall backs up through a four-entry result holder into char_stall.
module command_line_tokenizer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  clt_pkg::in_t  char_data,
  output logic          tok_valid,
  input  logic          tok_stall,
  output clt_pkg::out_t tok_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import clt_pkg::*;

  logic ignore_quotes;

  logic q_valid;
  in_t  q;

  st_t st;
  st_t st_next;

  out_t [RES_MAX-1:0] step_res;
  logic [CNT_W-1:0]   step_cnt;

  out_t [RES_MAX-1:0] res_buf;
  logic [CNT_W-1:0]   res_cnt;
  logic [PTR_W-1:0]   res_ptr;
  logic               busy;

  logic take;
  logic last_take;
  logic free;
  logic move;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IGNORE_QUOTES) ? {31'd0, ignore_quotes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_quotes <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_IGNORE_QUOTES) begin
      ignore_quotes <= pwdata[0];
    end
  end

  assign take      = busy && !tok_stall;
  assign last_take = take && ({1'b0, res_ptr} == res_cnt - 1'b1);
  assign free      = !busy || last_take;
  assign move      = q_valid && free;

  assign char_stall = q_valid && !free;
  assign tok_valid  = busy;
  assign tok_data   = res_buf[res_ptr];

  clt_step u_step (
    .st            (st),
    .item          (q),
    .ignore_quotes (ignore_quotes),
    .st_next       (st_next),
    .res           (step_res),
    .res_cnt       (step_cnt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (char_valid && !char_stall) begin
      q_valid <= 1'b1;
    end else if (move) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) q <= char_data;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (move) begin
      st <= st_next;
    end
  end

  // result holder, drained one beat per cycle while tok_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      res_cnt <= '0;
      res_ptr <= '0;
    end else if (move && step_cnt != '0) begin
      busy    <= 1'b1;
      res_cnt <= step_cnt;
      res_ptr <= '0;
    end else if (last_take) begin
      busy <= 1'b0;
    end else if (take) begin
      res_ptr <= res_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && step_cnt != '0) res_buf <= step_res;
  end

`ifndef SYNTHESIS
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (res_cnt != '0) && ({1'b0, res_ptr} < res_cnt))
    else $error("result holder pointer out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> q_valid && busy)
    else $error("input stalled without a pending result");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.result_kind == KIND_SUMMARY |-> tok_data.run_last)
    else $error("line summary not flagged as last result");

  a_token_cap: assert property (@(posedge clk) disable iff (rst)
    st.token_counter <= TOK_LIMIT)
    else $error("token counter beyond limit");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    take && !last_take |=> busy && res_ptr == PTR_W'($past(res_ptr) + 1'b1))
    else $error("result pointer did not advance");
`endif

endmodule

[verif/tb_command_line_tokenizer_top.sv]
module tb_command_line_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int GAP_MAX      = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RAND_CHARS   = 50;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_Z      = 8'h7A;

  typedef enum int {
    PART_WORD, PART_QUOTED, PART_BLOCK, PART_URL, PART_LINE_CMT, PART_NOISE, PART_BLANK
  } part_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  in_t         char_data;
  logic        tok_valid;
  logic        tok_stall;
  out_t        tok_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  command_line_tokenizer_top uut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_data (char_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5ns clk = ~clk;

  // tokenizer shadow state
  mode_t       p_mode;
  logic        p_slash;
  logic        p_star;
  logic        p_done;
  logic        p_ignq;
  logic [7:0]  p_prev1;
  logic [7:0]  p_prev2;
  int unsigned p_pos;
  int unsigned p_tokens;

  out_t        step_res[RES_MAX];
  int          step_n;
  out_t        pending_tok[$];

  int          mismatches = 0;
  int          cycles = 0;
  int          chars_sent = 0;
  logic        idle_on = 1'b1;
  logic        hold_rx = 1'b0;

  function automatic void push_res(logic [1:0] kind, logic [7:0] b, int unsigned idx);
    if (step_n < RES_MAX) begin
      step_res[step_n] = '{result_kind: kind, token_byte: b, token_index: idx[9:0],
                           token_total: p_tokens[10:0], run_last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c <= CH_SPACE || c >= 8'h80;
  endfunction

  function automatic logic quote_on(logic [7:0] c);
    return c == CH_DQUOTE && !p_ignq;
  endfunction

  function automatic void shift_hist(logic [7:0] c);
    p_prev2 = p_prev1;
    p_prev1 = c;
  endfunction

  function automatic void close_line();
    p_done  = 1'b1;
    p_slash = 1'b0;
    p_star  = 1'b0;
  endfunction

  function automatic void open_token();
    if (p_tokens != 32'hFFFF_FFFF) p_tokens++;
  endfunction

  function automatic void close_token();
    push_res(KIND_END, 8'h00, p_tokens - 1);
  endfunction

  function automatic void clear_line();
    p_mode   = MODE_BETWEEN;
    p_slash  = 1'b0;
    p_star   = 1'b0;
    p_prev1  = 8'h00;
    p_prev2  = 8'h00;
    p_pos    = 0;
    p_tokens = 0;
    p_done   = 1'b0;
  endfunction

  function automatic void eat_char(logic [7:0] c);
    case (p_mode)
      MODE_BETWEEN: begin
        if (c == CH_NUL) close_line();
        else if (is_blank(c)) shift_hist(c);
        else if (c == CH_SLASH) p_slash = 1'b1;
        else begin
          open_token();
          if (quote_on(c)) p_mode = MODE_QUOTE;
          else begin
            push_res(KIND_BYTE, c, p_tokens - 1);
            p_mode = MODE_TOKEN;
          end
          shift_hist(c);
        end
      end
      MODE_TOKEN: begin
        if (c == CH_NUL) begin
          close_token();
          close_line();
        end else if (is_blank(c) || quote_on(c)) begin
          close_token();
          if (p_tokens >= MAX_TOKENS) close_line();
          else begin
            if (quote_on(c)) begin
              open_token();
              p_mode = MODE_QUOTE;
            end else begin
              p_mode = MODE_BETWEEN;
            end
            shift_hist(c);
          end
        end else if (c == CH_SLASH) begin
          p_slash = 1'b1;
        end else begin
          push_res(KIND_BYTE, c, p_tokens - 1);
          shift_hist(c);
        end
      end
      MODE_QUOTE: begin
        if (c == CH_NUL) begin
          close_token();
          close_line();
        end else if (c == CH_DQUOTE) begin
          close_token();
          if (p_tokens >= MAX_TOKENS) close_line();
          else begin
            p_mode = MODE_BETWEEN;
            shift_hist(c);
          end
        end else begin
          push_res(KIND_BYTE, c, p_tokens - 1);
          shift_hist(c);
        end
      end
      default: begin
        if (c == CH_NUL) close_line();
        else begin
          if (p_star && c == CH_SLASH) begin
            p_mode = MODE_BETWEEN;
            p_star = 1'b0;
          end else begin
            p_star = (c == CH_STAR);
          end
          shift_hist(c);
        end
      end
    endcase
  endfunction

  // the byte after a held slash decides: line comment, block comment or plain byte
  function automatic void settle_slash(logic [7:0] c);
    logic keep;
    keep = p_pos >= 4 && p_prev1 == CH_COLON && p_prev2 >= CH_A && p_prev2 <= CH_Z;
    p_slash = 1'b0;
    if (c == CH_SLASH && !keep) begin
      if (p_mode == MODE_TOKEN) close_token();
      close_line();
    end else if (c == CH_STAR) begin
      if (p_mode == MODE_TOKEN) close_token();
      if (p_mode == MODE_TOKEN && p_tokens >= MAX_TOKENS) close_line();
      else begin
        p_mode = MODE_COMMENT;
        p_star = 1'b1;
        shift_hist(CH_SLASH);
        shift_hist(CH_STAR);
      end
    end else begin
      if (p_mode != MODE_TOKEN) begin
        open_token();
        p_mode = MODE_TOKEN;
      end
      push_res(KIND_BYTE, CH_SLASH, p_tokens - 1);
      shift_hist(CH_SLASH);
      eat_char(c);
    end
  endfunction

  function automatic void tokenize_char(logic [7:0] b, logic last);
    logic [7:0] c;
    c = b;
    step_n = 0;
    if (!p_done) begin
      if (p_pos >= MAX_LINE - 1) c = CH_NUL;
      if (p_slash) settle_slash(c);
      else eat_char(c);
      p_pos++;
    end
    if (last) begin
      if (!p_done) begin
        if (p_slash) settle_slash(CH_NUL);
        else eat_char(CH_NUL);
      end
      push_res(KIND_SUMMARY, 8'h00, 0);
      clear_line();
    end
    if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_tok.push_back(step_res[i]);
  endfunction

  function automatic void report_mismatch(string what, longint want, longint got);
    $display("%0t ERROR %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endfunction

  // result checker
  always @(posedge clk) begin : tok_check
    out_t want;
    out_t got;
    if (rst === 1'b0 && tok_valid === 1'b1 && tok_stall === 1'b0) begin
      got = tok_data;
      if (pending_tok.size() == 0) begin
        $display("%0t ERROR unexpected beat: expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_tok.pop_front();
        if (got.result_kind !== want.result_kind)
          report_mismatch("result_kind", want.result_kind, got.result_kind);
        if (got.token_byte !== want.token_byte)
          report_mismatch("token_byte", want.token_byte, got.token_byte);
        if (got.token_index !== want.token_index)
          report_mismatch("token_index", want.token_index, got.token_index);
        if (got.token_total !== want.token_total)
          report_mismatch("token_total", want.token_total, got.token_total);
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", want.run_last, got.run_last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall before each beat while idle_on is set, plus a long hold-off on request
  initial begin : rx_side
    int gap;
    tok_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        tok_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
        tok_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      tok_stall = 1'b0;
      do @(posedge clk); while (tok_valid !== 1'b1);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_char(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      char_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid = 1'b1;
    char_data  = '{in_byte: b, line_last: last};
    do @(posedge clk); while (char_stall !== 1'b0);
    tokenize_char(b, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last && (i == s.len() - 1));
  endtask

  task automatic drain_results();
    char_valid = 1'b0;
    while (pending_tok.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ignore_quotes(input logic v);
    drain_results();
    paddr   = {REG_IGNORE_QUOTES, 2'b00};
    pwdata  = {31'b0, v};
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    p_ignq = v;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {31'b0, v}) report_mismatch("ignore_quotes readback", v, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_plain_tokens();
    send_text("ab", 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'h21, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CH_Z, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_text("q", 1'b1);
  endtask

  task automatic test_quotes();
    send_text("a\"b c\" \"x", 1'b1);   // last quote left open
  endtask

  task automatic test_ignore_quotes();
    write_ignore_quotes(1'b1);
    send_text("a\"b \"c", 1'b1);
    write_ignore_quotes(1'b0);
  endtask

  task automatic test_comments();
    send_text("/*c*/d/*/e f/*g", 1'b1);
    send_text("ab://c//i", 1'b1);
    send_text("b://c", 1'b1);
    send_text("k/", 1'b1);
  endtask

  task automatic test_early_end();
    send_char(8'h6D, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_text("n o", 1'b1);
  endtask

  task automatic test_long_line();
    send_text("x", 1'b0);
    repeat (MAX_LINE - 4) send_char(CH_SPACE, 1'b0);
    send_text("ab", 1'b0);
    // first byte sits at the last position and acts as a terminator
    send_text("cde", 1'b1);
  endtask

  task automatic test_token_limit();
    repeat (MAX_TOKENS) begin
      send_char(8'($urandom_range(CH_A, CH_Z)), 1'b0);
      send_char(CH_SPACE, 1'b0);
    end
    send_text("b c", 1'b1);
  endtask

  task automatic send_rand_line();
    int    n_parts;
    int    len;
    int    r;
    part_t part;
    n_parts = $urandom_range(1, 5);
    for (int i = 0; i < n_parts; i++) begin
      r    = $urandom_range(0, 9);
      part = (r < 4) ? PART_WORD : part_t'(r - 3);
      len  = $urandom_range(1, 6);
      case (part)
        PART_WORD: begin
          repeat (len) begin
            if ($urandom_range(0, 1)) send_char(8'($urandom_range(CH_A, CH_Z)), 1'b0);
            else send_char(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
          end
        end
        PART_QUOTED: begin
          send_char(CH_DQUOTE, 1'b0);
          repeat (len) send_char(8'($urandom_range(1, 255)), 1'b0);
          send_char(CH_DQUOTE, 1'b0);
        end
        PART_BLOCK: begin
          send_text("/*", 1'b0);
          repeat (len) send_char(8'($urandom_range(1, 255)), 1'b0);
          send_text("*/", 1'b0);
        end
        PART_URL:      send_text("ab://c", 1'b0);
        PART_LINE_CMT: send_text("//z", 1'b0);
        PART_NOISE:    repeat (len) send_char(8'($urandom_range(0, 255)), 1'b0);
        default: begin
          if ($urandom_range(0, 1)) send_char(8'($urandom_range(1, 32)), 1'b0);
          else send_char(8'($urandom_range(128, 255)), 1'b0);
        end
      endcase
      send_char(CH_SPACE, 1'b0);
    end
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_random();
    int stop_at;
    for (int phase = 0; phase < 3; phase++) begin
      write_ignore_quotes(phase == 1);
      idle_on = (phase != 1);
      stop_at = chars_sent + RAND_CHARS;
      while (chars_sent < stop_at) send_rand_line();
    end
    idle_on = 1'b1;
    write_ignore_quotes(1'b0);
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    drain_results();
    idle_on = 1'b0;
    hold_rx = 1'b1;
    repeat (4) send_text("\"abcdefgh\" k/l mn", 1'b0);
    send_text("z", 1'b1);
    drain_results();
    idle_on = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    char_valid = 1'b0;
    char_data  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    clear_line();
    p_ignq = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_plain_tokens();
    test_quotes();
    test_comments();
    test_early_end();
    test_ignore_quotes();
    test_long_line();
    test_token_limit();
    test_random();
    test_backpressure();

    drain_results();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
